// File: rtl/core/v7d_pkg.sv
// ----------------------------------------------------------------------------
// v7d_pkg: shared types and constants for the 7-bit varint decoder
// Holds the mode codes, the decoder state and the per-word step result.
// ----------------------------------------------------------------------------
package v7d_pkg;

    localparam int ACC_W   = 64;
    localparam int COUNT_W = 8;
    localparam int LEFT_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int MODE_W  = 2;

    // decode modes; the unused code decodes as raw
    localparam logic [MODE_W-1:0] MODE_RAW     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLAMP32 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LENPFX  = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [ACC_W-1:0]   acc;
        logic [COUNT_W-1:0] seen;
        logic               ovf;
    } t_vstate;

    typedef struct packed {
        logic               emit;
        logic               ok;
        logic [ACC_W-1:0]   value;
        logic [COUNT_W-1:0] count;
    } t_step_res;

endpackage

// File: rtl/core/v7d_if.sv
// ----------------------------------------------------------------------------
// v7d_if: stream channels of the 7-bit varint decoder
// Input words carry a stream byte and the remaining buffer length; output
// words carry one decoded integer.
// ----------------------------------------------------------------------------
interface v7d_in_if;
    logic                          valid;
    logic                          ready;
    logic [v7d_pkg::BYTE_W-1:0]    data_byte;
    logic [v7d_pkg::LEFT_W-1:0]    bytes_left;

    modport source (output valid, output data_byte, output bytes_left, input ready);
    modport sink   (input valid, input data_byte, input bytes_left, output ready);
endinterface

interface v7d_out_if;
    logic                          valid;
    logic                          ready;
    logic [v7d_pkg::ACC_W-1:0]     decoded_value;
    logic [v7d_pkg::COUNT_W-1:0]   byte_count;
    logic                          success;

    modport source (output valid, output decoded_value, output byte_count,
                    output success, input ready);
    modport sink   (input valid, input decoded_value, input byte_count,
                    input success, output ready);
endinterface

// File: rtl/core/varint_7bit_decoder.sv
// ----------------------------------------------------------------------------
// varint_7bit_decoder: big-endian 7-bit varint stream decoder
// Decodes most-significant-group-first varints, one stream byte per word.
// ----------------------------------------------------------------------------
// One input word is taken every cycle while the output is not stalled. A
// word passes an input register, the combinational decode step that updates
// the accumulator, and a result register. A stall on the output holds both
// registers; the input stays ready while the result register is empty or
// being taken. The user must write decode_mode through i_cfg_we and
// i_cfg_wdata only while no word is in flight; the block does not enforce it.
module varint_7bit_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [v7d_pkg::MODE_W-1:0]    i_cfg_wdata,
    v7d_in_if.sink                        i_in,
    v7d_out_if.source                     o_out
);

    logic [v7d_pkg::MODE_W-1:0]   r_mode;
    logic                         r_in_valid;
    logic [v7d_pkg::BYTE_W-1:0]   r_byte;
    logic [v7d_pkg::LEFT_W-1:0]   r_left;
    v7d_pkg::t_vstate             r_state;
    v7d_pkg::t_vstate             n_state;
    v7d_pkg::t_step_res           step_res;
    logic                         r_out_valid;
    logic [v7d_pkg::ACC_W-1:0]    r_value;
    logic [v7d_pkg::COUNT_W-1:0]  r_count;
    logic                         r_ok;
    logic                         advance;
    logic                         step_fire;

    assign advance   = !r_out_valid || o_out.ready;
    assign step_fire = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    v7d_step u_step (
        .i_state     (r_state),
        .i_byte      (r_byte),
        .i_left      (r_left),
        .i_mode      (r_mode),
        .o_state_nxt (n_state),
        .o_res       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= v7d_pkg::MODE_RAW;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.data_byte;
            r_left <= i_in.bytes_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (step_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_fire && step_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire && step_res.emit) begin
            r_value <= step_res.value;
            r_count <= step_res.count;
            r_ok    <= step_res.ok;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.decoded_value = r_value;
    assign o_out.byte_count    = r_count;
    assign o_out.success       = r_ok;

    // a good integer always counts at least one byte
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_ok |-> r_count != 8'd0)
        else $error("successful word with zero byte count");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_ok |-> (r_count == 8'd0) && (r_value == '0))
        else $error("failure word with nonzero payload");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && ((r_mode == v7d_pkg::MODE_CLAMP32) ||
                        (r_mode == v7d_pkg::MODE_LENPFX)) |-> r_value[63:32] == 32'd0)
        else $error("clamped value above 32 bits");

    // state starts over after every emitted integer
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire && step_res.emit |=> (r_state.seen == 8'd0) && !r_state.ovf)
        else $error("decoder state not cleared after result");

endmodule

// File: rtl/core/v7d_step.sv
// ----------------------------------------------------------------------------
// v7d_step: one-byte decode step
// Shifts a 7-bit group into the accumulator and decides whether the word
// ends an integer, fails, or only advances the state.
// ----------------------------------------------------------------------------
module v7d_step (
    input  v7d_pkg::t_vstate              i_state,
    input  logic [v7d_pkg::BYTE_W-1:0]    i_byte,
    input  logic [v7d_pkg::LEFT_W-1:0]    i_left,
    input  logic [v7d_pkg::MODE_W-1:0]    i_mode,
    output v7d_pkg::t_vstate              o_state_nxt,
    output v7d_pkg::t_step_res            o_res
);

    logic                           ovf_nxt;
    logic [v7d_pkg::ACC_W-1:0]      acc_nxt;
    logic [v7d_pkg::COUNT_W-1:0]    seen_nxt;
    logic [v7d_pkg::ACC_W-1:0]      value;
    logic [v7d_pkg::LEFT_W-1:0]     left_m1;
    logic                           clamp;
    logic                           more;
    logic                           fail;

    // a group is lost once any of the top seven bits is set
    assign ovf_nxt  = i_state.ovf | (|i_state.acc[63:57]);
    assign acc_nxt  = {i_state.acc[56:0], i_byte[6:0]};
    assign seen_nxt = (i_state.seen == v7d_pkg::COUNT_MAX) ? i_state.seen
                                                           : i_state.seen + 8'd1;
    assign more     = i_byte[7];
    assign left_m1  = i_left - 16'd1;
    assign clamp    = (i_mode == v7d_pkg::MODE_CLAMP32) || (i_mode == v7d_pkg::MODE_LENPFX);

    always_comb begin
        value = ovf_nxt ? '1 : acc_nxt;
        if (clamp && (value[63:32] != 32'd0)) begin
            value = {32'd0, 32'hFFFF_FFFF};
        end
    end

    always_comb begin
        fail = 1'b0;
        if (more) begin
            fail = (i_left == 16'd1);
        end else if (i_mode == v7d_pkg::MODE_LENPFX) begin
            // value is already at most 32 bits here
            fail = (i_left == 16'd0) || (value[31:0] > {16'd0, left_m1});
        end
    end

    always_comb begin
        o_res.emit  = !more || fail;
        o_res.ok    = !fail;
        o_res.value = fail ? '0 : value;
        o_res.count = fail ? '0 : seen_nxt;
        if (o_res.emit) begin
            o_state_nxt = '0;
        end else begin
            o_state_nxt.acc  = acc_nxt;
            o_state_nxt.seen = seen_nxt;
            o_state_nxt.ovf  = ovf_nxt;
        end
    end

endmodule
